// File: rtl/base_integer_instruction_decoder_defines.svh
// Assertion macros for the base integer instruction decoder.
`ifndef BASE_INTEGER_INSTRUCTION_DECODER_DEFINES_SVH
`define BASE_INTEGER_INSTRUCTION_DECODER_DEFINES_SVH

// Same-cycle implication, off while reset is held
`define BID_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held
`define BID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bid_pkg.sv
// Shared types and constants for the base integer instruction decoder.
package bid_pkg;

    // Decoded operation, in base integer ISA order
    typedef enum logic [5:0] {
        OP_INVALID = 6'd0,
        OP_LUI     = 6'd1,
        OP_AUIPC   = 6'd2,
        OP_JAL     = 6'd3,
        OP_JALR    = 6'd4,
        OP_BEQ     = 6'd5,
        OP_BNE     = 6'd6,
        OP_BLT     = 6'd7,
        OP_BGE     = 6'd8,
        OP_BLTU    = 6'd9,
        OP_BGEU    = 6'd10,
        OP_LB      = 6'd11,
        OP_LH      = 6'd12,
        OP_LW      = 6'd13,
        OP_LBU     = 6'd14,
        OP_LHU     = 6'd15,
        OP_SB      = 6'd16,
        OP_SH      = 6'd17,
        OP_SW      = 6'd18,
        OP_ADDI    = 6'd19,
        OP_SLTI    = 6'd20,
        OP_SLTIU   = 6'd21,
        OP_XORI    = 6'd22,
        OP_ORI     = 6'd23,
        OP_ANDI    = 6'd24,
        OP_SLLI    = 6'd25,
        OP_SRLI    = 6'd26,
        OP_SRAI    = 6'd27,
        OP_ADD     = 6'd28,
        OP_SUB     = 6'd29,
        OP_SLL     = 6'd30,
        OP_SLT     = 6'd31,
        OP_SLTU    = 6'd32,
        OP_XOR     = 6'd33,
        OP_SRL     = 6'd34,
        OP_SRA     = 6'd35,
        OP_OR      = 6'd36,
        OP_AND     = 6'd37
    } t_op;

    // Encoding format
    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_R    = 3'd1,
        FMT_I    = 3'd2,
        FMT_S    = 3'd3,
        FMT_B    = 3'd4,
        FMT_U    = 3'd5,
        FMT_J    = 3'd6
    } t_fmt;

    // Result of classification
    typedef struct packed {
        t_op  op;
        t_fmt fmt;
    } t_decode;

    // Major opcodes
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;

    // funct7 values
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // funct3 values
    localparam logic [2:0] F3_0 = 3'd0;
    localparam logic [2:0] F3_1 = 3'd1;
    localparam logic [2:0] F3_2 = 3'd2;
    localparam logic [2:0] F3_3 = 3'd3;
    localparam logic [2:0] F3_4 = 3'd4;
    localparam logic [2:0] F3_5 = 3'd5;
    localparam logic [2:0] F3_6 = 3'd6;
    localparam logic [2:0] F3_7 = 3'd7;

endpackage

// File: rtl/bid_classify.sv
// Operation and format classification from opcode, funct3 and funct7.
module bid_classify (
    input  logic [31:0]           i_word,
    output bid_pkg::t_decode      o_decode
);
    import bid_pkg::*;

    logic [6:0] w_opc;
    logic [2:0] w_f3;
    logic [6:0] w_f7;
    t_op        w_op;
    t_fmt       w_fmt;

    assign w_opc = i_word[6:0];
    assign w_f3  = i_word[14:12];
    assign w_f7  = i_word[31:25];

    // Opcode decode, then funct3/funct7 refine the operation
    always_comb begin
        w_op  = OP_INVALID;
        w_fmt = FMT_NONE;
        unique case (w_opc)
            OPC_LUI: begin
                w_op  = OP_LUI;
                w_fmt = FMT_U;
            end
            OPC_AUIPC: begin
                w_op  = OP_AUIPC;
                w_fmt = FMT_U;
            end
            OPC_JAL: begin
                w_op  = OP_JAL;
                w_fmt = FMT_J;
            end
            OPC_JALR: begin
                w_fmt = FMT_I;
                if (w_f3 == F3_0) begin
                    w_op = OP_JALR;
                end
            end
            OPC_BRANCH: begin
                w_fmt = FMT_B;
                unique case (w_f3)
                    F3_0:    w_op = OP_BEQ;
                    F3_1:    w_op = OP_BNE;
                    F3_4:    w_op = OP_BLT;
                    F3_5:    w_op = OP_BGE;
                    F3_6:    w_op = OP_BLTU;
                    F3_7:    w_op = OP_BGEU;
                    default: w_op = OP_INVALID;
                endcase
            end
            OPC_LOAD: begin
                w_fmt = FMT_I;
                unique case (w_f3)
                    F3_0:    w_op = OP_LB;
                    F3_1:    w_op = OP_LH;
                    F3_2:    w_op = OP_LW;
                    F3_4:    w_op = OP_LBU;
                    F3_5:    w_op = OP_LHU;
                    default: w_op = OP_INVALID;
                endcase
            end
            OPC_STORE: begin
                w_fmt = FMT_S;
                unique case (w_f3)
                    F3_0:    w_op = OP_SB;
                    F3_1:    w_op = OP_SH;
                    F3_2:    w_op = OP_SW;
                    default: w_op = OP_INVALID;
                endcase
            end
            OPC_OP_IMM: begin
                w_fmt = FMT_I;
                unique case (w_f3)
                    F3_0: w_op = OP_ADDI;
                    F3_1: w_op = (w_f7 == F7_BASE) ? OP_SLLI : OP_INVALID;
                    F3_2: w_op = OP_SLTI;
                    F3_3: w_op = OP_SLTIU;
                    F3_4: w_op = OP_XORI;
                    F3_5: begin
                        if (w_f7 == F7_BASE) begin
                            w_op = OP_SRLI;
                        end else if (w_f7 == F7_ALT) begin
                            w_op = OP_SRAI;
                        end
                    end
                    F3_6: w_op = OP_ORI;
                    F3_7: w_op = OP_ANDI;
                endcase
            end
            OPC_OP: begin
                w_fmt = FMT_R;
                if (w_f7 == F7_BASE) begin
                    unique case (w_f3)
                        F3_0: w_op = OP_ADD;
                        F3_1: w_op = OP_SLL;
                        F3_2: w_op = OP_SLT;
                        F3_3: w_op = OP_SLTU;
                        F3_4: w_op = OP_XOR;
                        F3_5: w_op = OP_SRL;
                        F3_6: w_op = OP_OR;
                        F3_7: w_op = OP_AND;
                    endcase
                end else if (w_f7 == F7_ALT && w_f3 == F3_0) begin
                    w_op = OP_SUB;
                end else if (w_f7 == F7_ALT && w_f3 == F3_5) begin
                    w_op = OP_SRA;
                end
            end
            default: begin
                w_op  = OP_INVALID;
                w_fmt = FMT_NONE;
            end
        endcase
        // an unrecognised word carries no format
        if (w_op == OP_INVALID) begin
            w_fmt = FMT_NONE;
        end
    end

    assign o_decode.op  = w_op;
    assign o_decode.fmt = w_fmt;

endmodule

// File: rtl/bid_imm.sv
// Immediate assembly and sign extension, selected by encoding format.
module bid_imm (
    input  logic [31:0]        i_word,
    input  bid_pkg::t_fmt      i_fmt,
    output logic [31:0]        o_imm
);
    import bid_pkg::*;

    logic [31:0] w_imm_i;
    logic [31:0] w_imm_s;
    logic [31:0] w_imm_b;
    logic [31:0] w_imm_u;
    logic [31:0] w_imm_j;

    // Per-format immediates; bit 31 is the sign in every format
    assign w_imm_i = {{20{i_word[31]}}, i_word[31:20]};
    assign w_imm_s = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign w_imm_b = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                      i_word[11:8], 1'b0};
    assign w_imm_u = {i_word[31:12], 12'd0};
    assign w_imm_j = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                      i_word[30:21], 1'b0};

    // Format select; R and invalid give zero
    always_comb begin
        unique case (i_fmt)
            FMT_I:   o_imm = w_imm_i;
            FMT_S:   o_imm = w_imm_s;
            FMT_B:   o_imm = w_imm_b;
            FMT_U:   o_imm = w_imm_u;
            FMT_J:   o_imm = w_imm_j;
            default: o_imm = 32'd0;
        endcase
    end

endmodule

// File: rtl/base_integer_instruction_decoder.sv
// Top level of the base integer instruction decoder: handshake and pipeline registers.
// Decodes one RV32I instruction word per item into operation, format, register fields and
// the sign-extended immediate. One item is taken every cycle while the output is not
// stalled; each item passes through the input register and then the result register,
// with the decode logic between the two. Both stages advance
// independently, so one more item is taken while a finished result waits to be collected.
// There is no state beyond the pipeline and no configuration.
`include "base_integer_instruction_decoder_defines.svh"

module base_integer_instruction_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_instruction_word,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [5:0]         o_operation,
    output logic [2:0]         o_encoding_format,
    output logic [4:0]         o_dest_register,
    output logic [4:0]         o_source_register_one,
    output logic [4:0]         o_source_register_two,
    output logic signed [31:0] o_immediate_value
);
    import bid_pkg::*;

    logic        r_in_valid;
    logic        n_in_valid;
    logic [31:0] r_word;
    logic        r_out_valid;
    logic        n_out_valid;
    t_decode     r_decode;
    logic [31:0] r_imm;
    logic [4:0]  r_rd;
    logic [4:0]  r_rs1;
    logic [4:0]  r_rs2;

    logic        w_in_ready;
    logic        w_out_ready;
    t_decode     w_decode;
    logic [31:0] w_imm;

    // Stage advance: result register frees when empty or collected
    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_in_ready  = !r_in_valid || w_out_ready;
    assign o_stall     = !w_in_ready;

    assign n_in_valid  = w_in_ready ? i_valid : r_in_valid;
    assign n_out_valid = w_out_ready ? r_in_valid : r_out_valid;

    // Decode logic between the two registers
    bid_classify u_classify (
        .i_word   (r_word),
        .o_decode (w_decode)
    );

    bid_imm u_imm (
        .i_word (r_word),
        .i_fmt  (w_decode.fmt),
        .o_imm  (w_imm)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_valid) begin
            r_word <= i_instruction_word;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_in_valid) begin
            r_decode <= w_decode;
            r_imm    <= w_imm;
            r_rd     <= r_word[11:7];
            r_rs1    <= r_word[19:15];
            r_rs2    <= r_word[24:20];
        end
    end

    assign o_valid               = r_out_valid;
    assign o_operation           = r_decode.op;
    assign o_encoding_format     = r_decode.fmt;
    assign o_dest_register       = r_rd;
    assign o_source_register_one = r_rs1;
    assign o_source_register_two = r_rs2;
    assign o_immediate_value     = $signed(r_imm);

    // Checks
    `BID_ASSERT_NOW(a_invalid_clean, i_clk, i_rst_n,
        o_valid && o_operation == OP_INVALID,
        o_encoding_format == FMT_NONE && o_immediate_value == 32'sd0,
        "invalid item with format or immediate set")
    `BID_ASSERT_NOW(a_rfmt_no_imm, i_clk, i_rst_n,
        o_valid && o_encoding_format == FMT_R,
        o_immediate_value == 32'sd0,
        "R-format item with non-zero immediate")
    `BID_ASSERT_NOW(a_ufmt_low_zero, i_clk, i_rst_n,
        o_valid && o_encoding_format == FMT_U,
        o_immediate_value[11:0] == 12'd0,
        "U-format immediate with low bits set")
    `BID_ASSERT_NEXT(a_held_item_kept, i_clk, i_rst_n,
        r_in_valid && !w_out_ready,
        r_in_valid,
        "item in input register lost while result stalled")
    `BID_ASSERT_NOW(a_stall_only_full, i_clk, i_rst_n,
        o_stall,
        r_in_valid && r_out_valid && i_stall,
        "input stalled while a stage was free")

endmodule

// File: tb/sv/base_integer_instruction_decoder_tb.sv
// Self-checking testbench for the base integer instruction decoder.
`timescale 1ns / 100ps

module base_integer_instruction_decoder_tb;
    import bid_pkg::*;

    // Opcodes that the decoder treats as invalid
    localparam logic [6:0] OPC_SYSTEM   = 7'h73;
    localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
    localparam int RANDOM_WORDS = 1350;
    localparam int PHASE_LEN    = 150;
    localparam int CYCLE_LIMIT  = 200000;

    // Fields of one decoded result
    typedef struct {
        t_op         op;
        t_fmt        fmt;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
    } t_decoded_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_instruction_word = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [5:0]  o_operation;
    logic [2:0]  o_encoding_format;
    logic [4:0]  o_dest_register;
    logic [4:0]  o_source_register_one;
    logic [4:0]  o_source_register_two;
    logic signed [31:0] o_immediate_value;

    logic [31:0]   fetch_q[$];
    t_decoded_word decoded_q[$];
    logic          word_taken = 1'b0;
    int            words_sent = 0;
    int            idle_phase = 0;
    int            gap_pct = 0;
    int            stall_pct = 0;
    int            error_count = 0;
    int            cycle_count = 0;

    base_integer_instruction_decoder DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_instruction_word    (i_instruction_word),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_operation           (o_operation),
        .o_encoding_format     (o_encoding_format),
        .o_dest_register       (o_dest_register),
        .o_source_register_one (o_source_register_one),
        .o_source_register_two (o_source_register_two),
        .o_immediate_value     (o_immediate_value)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Expected decode of one instruction word
    function automatic t_decoded_word decode_word(input logic [31:0] w);
        t_decoded_word d;
        logic [2:0] f3;
        logic [6:0] f7;
        f3    = w[14:12];
        f7    = w[31:25];
        d.op  = OP_INVALID;
        d.fmt = FMT_NONE;
        d.rd  = w[11:7];
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        d.imm = '0;
        case (w[6:0])
            OPC_LUI: begin
                d.op = OP_LUI;   d.fmt = FMT_U;
            end
            OPC_AUIPC: begin
                d.op = OP_AUIPC; d.fmt = FMT_U;
            end
            OPC_JAL: begin
                d.op = OP_JAL;   d.fmt = FMT_J;
            end
            OPC_JALR: begin
                d.fmt = FMT_I;
                if (f3 == F3_0) d.op = OP_JALR;
            end
            OPC_BRANCH: begin
                d.fmt = FMT_B;
                case (f3)
                    F3_0: d.op = OP_BEQ;
                    F3_1: d.op = OP_BNE;
                    F3_4: d.op = OP_BLT;
                    F3_5: d.op = OP_BGE;
                    F3_6: d.op = OP_BLTU;
                    F3_7: d.op = OP_BGEU;
                    default: d.op = OP_INVALID;
                endcase
            end
            OPC_LOAD: begin
                d.fmt = FMT_I;
                case (f3)
                    F3_0: d.op = OP_LB;
                    F3_1: d.op = OP_LH;
                    F3_2: d.op = OP_LW;
                    F3_4: d.op = OP_LBU;
                    F3_5: d.op = OP_LHU;
                    default: d.op = OP_INVALID;
                endcase
            end
            OPC_STORE: begin
                d.fmt = FMT_S;
                case (f3)
                    F3_0: d.op = OP_SB;
                    F3_1: d.op = OP_SH;
                    F3_2: d.op = OP_SW;
                    default: d.op = OP_INVALID;
                endcase
            end
            OPC_OP_IMM: begin
                d.fmt = FMT_I;
                case (f3)
                    F3_0: d.op = OP_ADDI;
                    F3_1: d.op = (f7 == F7_BASE) ? OP_SLLI : OP_INVALID;
                    F3_2: d.op = OP_SLTI;
                    F3_3: d.op = OP_SLTIU;
                    F3_4: d.op = OP_XORI;
                    F3_5: d.op = (f7 == F7_BASE) ? OP_SRLI :
                                 (f7 == F7_ALT)  ? OP_SRAI : OP_INVALID;
                    F3_6: d.op = OP_ORI;
                    default: d.op = OP_ANDI;
                endcase
            end
            OPC_OP: begin
                d.fmt = FMT_R;
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_0: d.op = OP_ADD;
                        F3_1: d.op = OP_SLL;
                        F3_2: d.op = OP_SLT;
                        F3_3: d.op = OP_SLTU;
                        F3_4: d.op = OP_XOR;
                        F3_5: d.op = OP_SRL;
                        F3_6: d.op = OP_OR;
                        default: d.op = OP_AND;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_0) begin
                    d.op = OP_SUB;
                end else if (f7 == F7_ALT && f3 == F3_5) begin
                    d.op = OP_SRA;
                end
            end
            default: d.op = OP_INVALID;
        endcase
        if (d.op == OP_INVALID) d.fmt = FMT_NONE;

        // Immediate picked by format, zero for R and invalid words
        case (d.fmt)
            FMT_I: d.imm = {{20{w[31]}}, w[31:20]};
            FMT_S: d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
            FMT_B: d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            FMT_U: d.imm = {w[31:12], 12'b0};
            FMT_J: d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            default: d.imm = '0;
        endcase
        return d;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Stimulus, reset and end of run
    initial begin
        logic [31:0] word;
        logic [6:0]  opc;
        int          pick;

        // Directed words: field extremes, corner encodings, unsupported opcodes
        fetch_q.push_back(32'h0000_0000);
        fetch_q.push_back(32'hFFFF_FFFF);
        fetch_q.push_back({20'hFFFFF, 5'd31, OPC_LUI});
        fetch_q.push_back({20'h80000, 5'd0, OPC_AUIPC});
        fetch_q.push_back({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL});
        fetch_q.push_back({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd31, OPC_JAL});
        fetch_q.push_back({12'hFFF, 5'd31, F3_0, 5'd1, OPC_JALR});
        fetch_q.push_back({12'h001, 5'd2, F3_1, 5'd3, OPC_JALR});
        fetch_q.push_back({7'h7F, 5'd31, 5'd31, F3_0, 5'h1F, OPC_BRANCH});
        fetch_q.push_back({7'h40, 5'd5, 5'd6, F3_7, 5'h00, OPC_BRANCH});
        fetch_q.push_back({7'h00, 5'd5, 5'd6, F3_2, 5'h01, OPC_BRANCH});
        fetch_q.push_back({12'h800, 5'd1, F3_2, 5'd2, OPC_LOAD});
        fetch_q.push_back({12'h7FF, 5'd1, F3_3, 5'd2, OPC_LOAD});
        fetch_q.push_back({7'h7F, 5'd31, 5'd0, F3_2, 5'h1F, OPC_STORE});
        fetch_q.push_back({7'h3F, 5'd1, 5'd2, F3_3, 5'h1E, OPC_STORE});
        fetch_q.push_back({12'h800, 5'd0, F3_0, 5'd31, OPC_OP_IMM});
        fetch_q.push_back({F7_BASE, 5'd31, 5'd1, F3_1, 5'd2, OPC_OP_IMM});
        // shift-immediate with a non-zero upper field is not a legal SLLI
        fetch_q.push_back({F7_ALT, 5'd31, 5'd1, F3_1, 5'd2, OPC_OP_IMM});
        // SRAI keeps its upper bits in the immediate
        fetch_q.push_back({F7_ALT, 5'd7, 5'd1, F3_5, 5'd2, OPC_OP_IMM});
        fetch_q.push_back({7'h01, 5'd7, 5'd1, F3_5, 5'd2, OPC_OP_IMM});
        fetch_q.push_back({F7_ALT, 5'd3, 5'd2, F3_0, 5'd1, OPC_OP});
        fetch_q.push_back({F7_ALT, 5'd31, 5'd31, F3_5, 5'd31, OPC_OP});
        fetch_q.push_back({F7_ALT, 5'd3, 5'd2, F3_1, 5'd1, OPC_OP});
        fetch_q.push_back({7'h01, 5'd3, 5'd2, F3_0, 5'd1, OPC_OP});
        fetch_q.push_back({12'h000, 5'd0, F3_0, 5'd0, OPC_SYSTEM});
        fetch_q.push_back({12'h001, 5'd0, F3_0, 5'd0, OPC_SYSTEM});
        fetch_q.push_back({4'h0, 4'hF, 4'hF, 5'd0, F3_0, 5'd0, OPC_MISC_MEM});

        // Random words: mostly legal opcodes with random fields, some pure noise
        repeat (RANDOM_WORDS) begin
            word = $urandom;
            if ($urandom_range(99) >= 10) begin
                case ($urandom_range(8))
                    0: opc = OPC_LUI;
                    1: opc = OPC_AUIPC;
                    2: opc = OPC_JAL;
                    3: opc = OPC_JALR;
                    4: opc = OPC_BRANCH;
                    5: opc = OPC_LOAD;
                    6: opc = OPC_STORE;
                    7: opc = OPC_OP_IMM;
                    default: opc = OPC_OP;
                endcase
                word[6:0] = opc;
                pick = $urandom_range(99);
                if (pick < 45)
                    word[31:25] = F7_BASE;
                else if (pick < 90)
                    word[31:25] = F7_ALT;
            end
            fetch_q.push_back(word);
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every word sent, every result collected, then a short settle
        wait (fetch_q.size() == 0 && !i_valid);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[base_integer_instruction_decoder] OK");
        end else begin
            $display("[base_integer_instruction_decoder] ERROR");
        end
        $finish;
    end

    // Driver: new item or idle at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            idle_phase = (words_sent / PHASE_LEN) % 4;
            gap_pct    = (idle_phase == 1) ? 73 : (idle_phase == 3) ? 13 : 0;
            stall_pct  = (idle_phase == 2) ? 73 : (idle_phase == 3) ? 13 : 0;
            i_stall <= ($urandom_range(99) < stall_pct);
            if (!i_valid || word_taken) begin
                if (fetch_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    i_valid            <= 1'b1;
                    i_instruction_word <= fetch_q.pop_front();
                    words_sent++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predict on input handshake, check on output handshake
    always @(posedge i_clk) begin
        word_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (decoded_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, op %0d imm %h",
                             $time, o_operation, o_immediate_value);
                end else begin
                    check_field("operation", 32'(decoded_q[0].op), 32'(o_operation));
                    check_field("encoding_format", 32'(decoded_q[0].fmt),
                                32'(o_encoding_format));
                    check_field("dest_register", 32'(decoded_q[0].rd),
                                32'(o_dest_register));
                    check_field("source_register_one", 32'(decoded_q[0].rs1),
                                32'(o_source_register_one));
                    check_field("source_register_two", 32'(decoded_q[0].rs2),
                                32'(o_source_register_two));
                    check_field("immediate_value", decoded_q[0].imm, o_immediate_value);
                    void'(decoded_q.pop_front());
                end
            end
            if (i_valid && !o_stall)
                decoded_q.push_back(decode_word(i_instruction_word));
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[base_integer_instruction_decoder] ERROR");
            $finish;
        end
    end

endmodule

// File: base_integer_instruction_decoder.f
+incdir+rtl
rtl/bid_pkg.sv
rtl/bid_classify.sv
rtl/bid_imm.sv
rtl/base_integer_instruction_decoder.sv
tb/sv/base_integer_instruction_decoder_tb.sv
